### rtl/xsu_pkg.sv
`default_nettype none
package xsu_pkg;

	localparam int unsigned STUB_SIZE = 46;
	localparam logic [5:0] TERM_POS = 6'd6;
	localparam logic [5:0] MARK_POS = 6'd28;
	localparam logic [8:0] ANY_TERM = 9'h100;
	localparam logic [8:0] ANY_MARK = 9'h101;
	localparam logic [15:0] MIN_PLAIN_RESET = 16'd32;

	// configuration register indexes
	localparam logic REG_ENTRY_OFFSET = 1'b0;
	localparam logic REG_MIN_PLAIN = 1'b1;

	typedef enum logic [2:0] {
		ST_RUN           = 3'd0,
		ST_OK            = 3'd1,
		ST_STUB_MISMATCH = 3'd2,
		ST_BAD_KEY       = 3'd3,
		ST_SHORT         = 3'd4
	} status_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  plain_byte;
		logic        finished;
		status_t     status;
		logic [31:0] plain_length;
		logic [8:0]  key_length;
	} res_t;

	localparam logic [8:0] STUB_PATTERN [STUB_SIZE] = '{
		9'h0eb, 9'h027, 9'h05b, 9'h053, 9'h05f, 9'h0b0, ANY_TERM, 9'h0fc,
		9'h0ae, 9'h075, 9'h0fd, 9'h057, 9'h059, 9'h053, 9'h05e, 9'h08a,
		9'h006, 9'h030, 9'h007, 9'h048, 9'h0ff, 9'h0c7, 9'h048, 9'h0ff,
		9'h0c6, 9'h066, 9'h081, 9'h03f, ANY_MARK, ANY_MARK, 9'h074, 9'h007,
		9'h080, 9'h03e, ANY_TERM, 9'h075, 9'h0ea, 9'h0eb, 9'h0e6, 9'h0ff,
		9'h0e1, 9'h0e8, 9'h0d4, 9'h0ff, 9'h0ff, 9'h0ff
	};

	function automatic logic [8:0] stub_pattern_at(input logic [5:0] idx);
		logic [8:0] w;
		w = 9'd0;
		if (32'(idx) < STUB_SIZE) begin
			w = STUB_PATTERN[idx];
		end
		return w;
	endfunction

endpackage
`default_nettype wire

### rtl/xsu_ram.sv
`default_nettype none
module xsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  wen,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/xsu_ctrl.sv
`default_nettype none
module xsu_ctrl #(
	parameter int KEY_DEPTH = 256,
	localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1,
	localparam int CW = $clog2(KEY_DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          object_end,
	input  wire logic [31:0]   entry_offset,
	input  wire logic [15:0]   min_plain_length,
	input  wire logic [7:0]    key_rdata,
	output logic               key_wen,
	output logic [AW-1:0]      key_waddr,
	output logic [7:0]         key_wdata,
	output logic [AW-1:0]      key_raddr,
	output xsu_pkg::res_t      res
);

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_STUB,
		PH_KEY,
		PH_CIPHER,
		PH_DONE
	} phase_t;

	localparam logic [CW-1:0] KEY_FULL = CW'(KEY_DEPTH);

	phase_t        phase_q, phase_d;
	logic [31:0]   pos_q, pos_d;
	logic [5:0]    stub_idx_q, stub_idx_d;
	logic [7:0]    term_q, term_d;
	logic [7:0]    mark_lo_q, mark_lo_d;
	logic [7:0]    mark_hi_q, mark_hi_d;
	logic [CW-1:0] key_cnt_q, key_cnt_d;
	logic [AW-1:0] key_ptr_q, key_ptr_d;
	logic [7:0]    held_q, held_d;
	logic          held_vld_q, held_vld_d;
	logic [31:0]   plain_cnt_q, plain_cnt_d;

	logic          take;
	logic          stub_ok;
	logic          wr;
	logic [8:0]    want;
	logic [CW+8:0] key_cnt_ext;
	xsu_pkg::status_t len_st_now;
	xsu_pkg::status_t len_st_next;

	assign len_st_now  = (plain_cnt_q >= 32'(min_plain_length)) ?
		xsu_pkg::ST_OK : xsu_pkg::ST_SHORT;
	assign want = xsu_pkg::stub_pattern_at(stub_idx_q);

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		stub_idx_d  = stub_idx_q;
		term_d      = term_q;
		mark_lo_d   = mark_lo_q;
		mark_hi_d   = mark_hi_q;
		key_cnt_d   = key_cnt_q;
		key_ptr_d   = key_ptr_q;
		held_d      = held_q;
		held_vld_d  = held_vld_q;
		plain_cnt_d = plain_cnt_q;
		take        = 1'b1;
		stub_ok     = 1'b1;
		wr          = 1'b0;
		res         = '0;
		key_cnt_ext = '0;

		if (phase_q == PH_WAIT) begin
			if (pos_q == entry_offset) begin
				phase_d = PH_STUB;
			end else begin
				pos_d = pos_q + 32'd1;
				take  = 1'b0;
			end
		end

		if (take) begin
			case (phase_d)
				PH_STUB: begin
					if (want == xsu_pkg::ANY_TERM) begin
						if (stub_idx_q == xsu_pkg::TERM_POS) begin
							term_d = data_byte;
						end else begin
							stub_ok = (data_byte == term_q);
						end
					end else if (want == xsu_pkg::ANY_MARK) begin
						if (stub_idx_q == xsu_pkg::MARK_POS) begin
							mark_lo_d = data_byte;
						end else begin
							mark_hi_d = data_byte;
						end
					end else begin
						stub_ok = (data_byte == want[7:0]);
					end
					if (!stub_ok) begin
						res.finished = 1'b1;
						res.status   = xsu_pkg::ST_STUB_MISMATCH;
						phase_d      = PH_DONE;
					end else begin
						stub_idx_d = stub_idx_q + 6'd1;
						if (32'(stub_idx_d) >= xsu_pkg::STUB_SIZE) begin
							phase_d   = PH_KEY;
							key_cnt_d = '0;
						end
					end
				end
				PH_KEY: begin
					if (data_byte == term_q) begin
						if (key_cnt_q == '0) begin
							res.finished = 1'b1;
							res.status   = xsu_pkg::ST_BAD_KEY;
							phase_d      = PH_DONE;
						end else begin
							phase_d     = PH_CIPHER;
							key_ptr_d   = '0;
							held_vld_d  = 1'b0;
							plain_cnt_d = '0;
						end
					end else if (key_cnt_q == KEY_FULL) begin
						res.finished = 1'b1;
						res.status   = xsu_pkg::ST_BAD_KEY;
						phase_d      = PH_DONE;
					end else begin
						wr        = 1'b1;
						key_cnt_d = key_cnt_q + CW'(1);
					end
				end
				PH_CIPHER: begin
					held_d     = data_byte;
					held_vld_d = 1'b1;
					if (held_vld_q) begin
						if (held_q == mark_lo_q && data_byte == mark_hi_q) begin
							// marker pair: neither byte is decoded
							held_d       = held_q;
							held_vld_d   = 1'b0;
							res.finished = 1'b1;
							res.status   = len_st_now;
							phase_d      = PH_DONE;
						end else begin
							res.byte_valid = 1'b1;
							res.plain_byte = held_q ^ key_rdata;
							if (32'(key_ptr_q) + 32'd1 >= 32'(key_cnt_q)) begin
								key_ptr_d = '0;
							end else begin
								key_ptr_d = key_ptr_q + AW'(1);
							end
							if (plain_cnt_q != '1) begin
								plain_cnt_d = plain_cnt_q + 32'd1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		len_st_next = (plain_cnt_d >= 32'(min_plain_length)) ?
			xsu_pkg::ST_OK : xsu_pkg::ST_SHORT;

		if (object_end && !res.finished && phase_d != PH_DONE) begin
			res.finished = 1'b1;
			case (phase_d)
				PH_WAIT, PH_STUB: res.status = xsu_pkg::ST_STUB_MISMATCH;
				PH_KEY:           res.status = xsu_pkg::ST_BAD_KEY;
				default:          res.status = len_st_next;
			endcase
		end

		key_cnt_ext      = {9'd0, key_cnt_d};
		res.plain_length = plain_cnt_d;
		res.key_length   = key_cnt_ext[8:0];

		// rearm for the next object once this beat's result is formed
		if (object_end) begin
			phase_d     = PH_WAIT;
			pos_d       = '0;
			stub_idx_d  = '0;
			term_d      = '0;
			mark_lo_d   = '0;
			mark_hi_d   = '0;
			key_cnt_d   = '0;
			key_ptr_d   = '0;
			held_d      = '0;
			held_vld_d  = 1'b0;
			plain_cnt_d = '0;
		end
	end

	assign key_wen   = accept && wr;
	assign key_waddr = key_cnt_q[AW-1:0];
	assign key_wdata = data_byte;
	// prefetch the key byte for the pointer that the next beat will use
	assign key_raddr = accept ? key_ptr_d : key_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			pos_q       <= '0;
			stub_idx_q  <= '0;
			term_q      <= '0;
			mark_lo_q   <= '0;
			mark_hi_q   <= '0;
			key_cnt_q   <= '0;
			key_ptr_q   <= '0;
			held_q      <= '0;
			held_vld_q  <= 1'b0;
			plain_cnt_q <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			stub_idx_q  <= stub_idx_d;
			term_q      <= term_d;
			mark_lo_q   <= mark_lo_d;
			mark_hi_q   <= mark_hi_d;
			key_cnt_q   <= key_cnt_d;
			key_ptr_q   <= key_ptr_d;
			held_q      <= held_d;
			held_vld_q  <= held_vld_d;
			plain_cnt_q <= plain_cnt_d;
		end
	end

endmodule
`default_nettype wire

### rtl/xor_stub_unwrap_decoder.sv
`default_nettype none
// Repeating-key XOR stub decoder. Feed an object one byte per beat on the slave
// stream, with s_tlast on its final byte; each input beat yields exactly one
// result beat, in order. Bytes before entry_offset are skipped, then a fixed
// 46-byte decryptor stub is matched, a key of 1 to KEY_DEPTH bytes is gathered
// up to the stub's terminator byte, and each later byte is XORed with the
// repeating key. Plaintext bytes lag the input by one beat so the stub's end
// marker pair can be caught. m_tlast flags the beat that closes decoding and
// m_tuser[3:1] carries its status; on a too-short status, drop the bytes
// already delivered. Throughput is one byte per clock unless m_tready stalls
// the output: each beat passes through one combinational step into the output
// register, and the key memory's registered read is issued a beat ahead.
// Write configuration registers only while the block is idle.
module xor_stub_unwrap_decoder #(
	parameter int KEY_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tlast,   // object_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // plain_byte, plain_length, key_length, zero pad
	output logic             m_tlast,   // finished
	output logic [3:0]       m_tuser    // byte_valid, status
);

	localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	logic [31:0]     entry_offset_q;
	logic [15:0]     min_plain_q;
	logic            accept;
	logic            key_wen;
	logic [AW-1:0]   key_waddr;
	logic [7:0]      key_wdata;
	logic [AW-1:0]   key_raddr;
	logic [7:0]      key_rdata;
	xsu_pkg::res_t   res;
	xsu_pkg::res_t   res_q;
	logic            out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_offset_q <= '0;
			min_plain_q    <= xsu_pkg::MIN_PLAIN_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				xsu_pkg::REG_ENTRY_OFFSET: entry_offset_q <= cfg_data;
				xsu_pkg::REG_MIN_PLAIN:    min_plain_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !out_vld_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	xsu_ram #(
		.WIDTH (8),
		.DEPTH (KEY_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.wen   (key_wen),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	xsu_ctrl #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.data_byte        (s_tdata),
		.object_end       (s_tlast),
		.entry_offset     (entry_offset_q),
		.min_plain_length (min_plain_q),
		.key_rdata        (key_rdata),
		.key_wen          (key_wen),
		.key_waddr        (key_waddr),
		.key_wdata        (key_wdata),
		.key_raddr        (key_raddr),
		.res              (res)
	);

	// output register: load on every accepted beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, res_q.key_length, res_q.plain_length, res_q.plain_byte};
	assign m_tlast  = res_q.finished;
	assign m_tuser  = {res_q.status, res_q.byte_valid};

endmodule
`default_nettype wire

### sim/xor_stub_unwrap_decoder_tb.sv
`timescale 1ns / 100ps

// Decryptor stub as it must appear in the object; wildcards take the
// terminator byte and the two end-marker bytes.
localparam logic [8:0] STUB_BYTES [46] = '{
	9'h0eb, 9'h027, 9'h05b, 9'h053, 9'h05f, 9'h0b0, xsu_pkg::ANY_TERM, 9'h0fc,
	9'h0ae, 9'h075, 9'h0fd, 9'h057, 9'h059, 9'h053, 9'h05e, 9'h08a,
	9'h006, 9'h030, 9'h007, 9'h048, 9'h0ff, 9'h0c7, 9'h048, 9'h0ff,
	9'h0c6, 9'h066, 9'h081, 9'h03f, xsu_pkg::ANY_MARK, xsu_pkg::ANY_MARK, 9'h074, 9'h007,
	9'h080, 9'h03e, xsu_pkg::ANY_TERM, 9'h075, 9'h0ea, 9'h0eb, 9'h0e6, 9'h0ff,
	9'h0e1, 9'h0e8, 9'h0d4, 9'h0ff, 9'h0ff, 9'h0ff
};

localparam int KEY_SLOTS = 256;

class decode_scoreboard;
	typedef enum {SKIPPING, MATCHING, KEYING, DECODING, CLOSED} stage_e;

	logic [31:0] entry_offset;
	logic [15:0] min_plain;

	stage_e      stage;
	logic [31:0] offset_seen;
	int          stub_at;
	logic [7:0]  term_byte;
	logic [7:0]  mark_lo;
	logic [7:0]  mark_hi;
	logic [7:0]  key_mem [KEY_SLOTS];
	int          key_len;
	int          key_at;
	logic [7:0]  lag_byte;
	bit          lag_full;
	logic [31:0] plain_total;

	xsu_pkg::res_t want_beats[$];
	int          beats_seen;
	int          fails;

	function new();
		entry_offset = '0;
		min_plain = xsu_pkg::MIN_PLAIN_RESET;
		beats_seen = 0;
		fails = 0;
		restart();
	endfunction

	function void restart();
		stage = SKIPPING;
		offset_seen = '0;
		stub_at = 0;
		term_byte = '0;
		mark_lo = '0;
		mark_hi = '0;
		key_len = 0;
		key_at = 0;
		lag_byte = '0;
		lag_full = 0;
		plain_total = '0;
	endfunction

	function xsu_pkg::status_t length_verdict();
		return (plain_total >= {16'd0, min_plain}) ? xsu_pkg::ST_OK : xsu_pkg::ST_SHORT;
	endfunction

	function void note_byte(logic [7:0] b, bit last);
		xsu_pkg::res_t r;
		bit consumed;
		bit good;
		bit marker_seen;
		logic [8:0] pat;
		r = '0;
		r.status = xsu_pkg::ST_RUN;
		consumed = 1;
		if (stage == SKIPPING) begin
			if (offset_seen == entry_offset) begin
				stage = MATCHING;
				stub_at = 0;
			end else begin
				offset_seen++;
				consumed = 0;
			end
		end
		if (consumed) begin
			case (stage)
				MATCHING: begin
					pat = STUB_BYTES[stub_at];
					good = 1;
					if (pat == xsu_pkg::ANY_TERM) begin
						if (stub_at == int'(xsu_pkg::TERM_POS)) term_byte = b;
						else good = (b == term_byte);
					end else if (pat == xsu_pkg::ANY_MARK) begin
						if (stub_at == int'(xsu_pkg::MARK_POS)) mark_lo = b;
						else mark_hi = b;
					end else begin
						good = (b == pat[7:0]);
					end
					if (!good) begin
						r.finished = 1;
						r.status = xsu_pkg::ST_STUB_MISMATCH;
						stage = CLOSED;
					end else begin
						stub_at++;
						if (stub_at >= 46) begin
							stage = KEYING;
							key_len = 0;
						end
					end
				end
				KEYING: begin
					if (b == term_byte) begin
						if (key_len == 0) begin
							r.finished = 1;
							r.status = xsu_pkg::ST_BAD_KEY;
							stage = CLOSED;
						end else begin
							stage = DECODING;
							key_at = 0;
							lag_full = 0;
							plain_total = '0;
						end
					end else if (key_len >= KEY_SLOTS) begin
						r.finished = 1;
						r.status = xsu_pkg::ST_BAD_KEY;
						stage = CLOSED;
					end else begin
						key_mem[key_len] = b;
						key_len++;
					end
				end
				DECODING: begin
					marker_seen = 0;
					if (lag_full) begin
						if (lag_byte == mark_lo && b == mark_hi) begin
							marker_seen = 1;
							lag_full = 0;
							r.finished = 1;
							r.status = length_verdict();
							stage = CLOSED;
						end else begin
							r.byte_valid = 1;
							r.plain_byte = lag_byte ^ key_mem[key_at];
							key_at++;
							if (key_at >= key_len) key_at = 0;
							if (plain_total != '1) plain_total++;
						end
					end
					if (!marker_seen) begin
						lag_byte = b;
						lag_full = 1;
					end
				end
				default: begin
				end
			endcase
		end
		if (last && !r.finished && stage != CLOSED) begin
			r.finished = 1;
			if (stage == SKIPPING || stage == MATCHING) r.status = xsu_pkg::ST_STUB_MISMATCH;
			else if (stage == KEYING) r.status = xsu_pkg::ST_BAD_KEY;
			else r.status = length_verdict();
		end
		r.plain_length = plain_total;
		r.key_length = 9'(key_len);
		want_beats.push_back(r);
		if (last) restart();
	endfunction

	task report(string line);
		$display("beat %0d: %s", beats_seen, line);
		fails++;
	endtask

	task check_beat(xsu_pkg::res_t got);
		xsu_pkg::res_t want;
		if (want_beats.size() == 0) begin
			report("result beat with nothing outstanding");
		end else begin
			want = want_beats.pop_front();
			if (got.byte_valid !== want.byte_valid)
				report($sformatf("byte_valid %0b, expected %0b", got.byte_valid, want.byte_valid));
			if (got.plain_byte !== want.plain_byte)
				report($sformatf("plain_byte %0h, expected %0h", got.plain_byte, want.plain_byte));
			if (got.finished !== want.finished)
				report($sformatf("finished %0b, expected %0b", got.finished, want.finished));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", 3'(got.status), 3'(want.status)));
			if (got.plain_length !== want.plain_length)
				report($sformatf("plain_length %0d, expected %0d",
					got.plain_length, want.plain_length));
			if (got.key_length !== want.key_length)
				report($sformatf("key_length %0d, expected %0d", got.key_length, want.key_length));
		end
		beats_seen++;
	endtask
endclass

module xor_stub_unwrap_decoder_tb;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum {
		OBJ_MARKER, OBJ_RUN_OUT, OBJ_BAD_STUB, OBJ_EMPTY_KEY,
		OBJ_NO_TERM, OBJ_CUT_STUB, OBJ_NOISE, OBJ_LONG_KEY
	} obj_kind_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_index = xsu_pkg::REG_ENTRY_OFFSET;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	decode_scoreboard sb;
	bit calm = 0;
	int sent_count = 0;
	int cycles = 0;

	xor_stub_unwrap_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		xsu_pkg::res_t got;
		m_tready <= calm || ($urandom_range(99) >= 9);
		if (arst_n && m_tvalid && m_tready) begin
			got.byte_valid = m_tuser[0];
			got.status = xsu_pkg::status_t'(m_tuser[3:1]);
			got.finished = m_tlast;
			got.plain_byte = m_tdata[7:0];
			got.plain_length = m_tdata[39:8];
			got.key_length = m_tdata[48:40];
			sb.check_beat(got);
		end
	end

	// Call at a rising edge; returns at the edge where the beat is taken.
	task automatic send_byte(input logic [7:0] b, input bit last);
		while (!calm && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b, last);
		sent_count++;
	endtask

	task automatic set_config(input logic [31:0] entry, input logic [15:0] min_len);
		s_tvalid <= 1'b0;
		while (sb.want_beats.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= xsu_pkg::REG_ENTRY_OFFSET;
		cfg_data <= entry;
		@(posedge clk);
		cfg_index <= xsu_pkg::REG_MIN_PLAIN;
		// upper bits are outside the register and must be ignored
		cfg_data <= {16'($urandom), min_len};
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.entry_offset = entry;
		sb.min_plain = min_len;
	endtask

	// Build one object: skipped lead-in, stub, key, terminator, ciphertext,
	// then bend it according to the kind.
	task automatic run_object(input obj_kind_e kind, input int key_force);
		logic [7:0] bytes[$];
		logic [7:0] term, mlow, mhigh, v;
		int klen, clen, pos;
		term = 8'($urandom);
		mlow = 8'($urandom);
		mhigh = 8'($urandom);
		if (kind == OBJ_NOISE) begin
			repeat ($urandom_range(1, 20)) bytes.push_back(8'($urandom));
		end else begin
			repeat (sb.entry_offset) bytes.push_back(8'($urandom));
			for (int i = 0; i < 46; i++) begin
				if (STUB_BYTES[i] == xsu_pkg::ANY_TERM) v = term;
				else if (STUB_BYTES[i] == xsu_pkg::ANY_MARK)
					v = (i == int'(xsu_pkg::MARK_POS)) ? mlow : mhigh;
				else v = STUB_BYTES[i][7:0];
				bytes.push_back(v);
			end
			if (kind == OBJ_BAD_STUB) begin
				do pos = $urandom_range(45); while (pos == 28 || pos == 29);
				bytes[bytes.size() - 46 + pos] ^= 8'($urandom_range(1, 255));
			end
			if (kind == OBJ_CUT_STUB) begin
				repeat ($urandom_range(1, 45)) void'(bytes.pop_back());
			end else begin
				klen = $urandom_range(1, 8);
				if ((kind == OBJ_MARKER || kind == OBJ_RUN_OUT) && $urandom_range(7) == 0)
					klen = $urandom_range(1) ? KEY_SLOTS : $urandom_range(200, 255);
				if (kind == OBJ_EMPTY_KEY) klen = 0;
				if (kind == OBJ_NO_TERM) klen = $urandom_range(0, 10);
				if (kind == OBJ_LONG_KEY) klen = $urandom_range(KEY_SLOTS + 1, KEY_SLOTS + 3);
				if (key_force >= 0) klen = key_force;
				repeat (klen) begin
					v = 8'($urandom);
					while (v == term) v = 8'($urandom);
					bytes.push_back(v);
				end
				if (kind != OBJ_NO_TERM) begin
					bytes.push_back(term);
					clen = (kind == OBJ_MARKER || kind == OBJ_RUN_OUT) ?
						$urandom_range(0, 70) : $urandom_range(0, 5);
					repeat (clen) bytes.push_back(8'($urandom));
					if (kind == OBJ_MARKER) begin
						bytes.push_back(mlow);
						bytes.push_back(mhigh);
						repeat ($urandom_range(0, 4)) bytes.push_back(8'($urandom));
					end
				end
			end
		end
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	initial begin
		int stop_at, r;
		obj_kind_e kind;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte objects: stub start cut off, first byte wrong
		send_byte(8'heb, 1'b1);
		send_byte(8'h00, 1'b1);
		// mismatch, then dead bytes up to the end; then a stub cut off after three bytes
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b1);
		send_byte(8'heb, 1'b0);
		send_byte(8'h27, 1'b0);
		send_byte(8'h5b, 1'b1);
		for (int k = 0; k <= int'(OBJ_LONG_KEY); k++) run_object(obj_kind_e'(k), -1);
		run_object(OBJ_MARKER, KEY_SLOTS);
		run_object(OBJ_RUN_OUT, 1);

		for (int p = 0; p < 7; p++) begin
			case (p)
				1: set_config(32'd0, 16'd0);
				2: set_config(32'd5, 16'hffff);
				3: set_config('1, 16'd16);
				4: set_config($urandom_range(0, 7), $urandom_range(0, 40));
				5: set_config(32'd1, $urandom_range(0, 65535));
				6: set_config($urandom_range(2, 7), 16'd32);
				default: begin
				end
			endcase
			calm <= (p == 2);
			stop_at = sent_count + ((p == 2) ? 120 : (p == 3) ? 40 : 15);
			while (sent_count < stop_at) begin
				r = $urandom_range(99);
				kind = (r < 45) ? OBJ_MARKER : (r < 63) ? OBJ_RUN_OUT :
					(r < 71) ? OBJ_BAD_STUB : (r < 76) ? OBJ_EMPTY_KEY :
					(r < 83) ? OBJ_NO_TERM : (r < 91) ? OBJ_CUT_STUB :
					(r < 97) ? OBJ_NOISE : OBJ_LONG_KEY;
				// nothing past the lead-in is reachable at the largest offset
				if (p == 3) kind = OBJ_NOISE;
				run_object(kind, -1);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.want_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
